/* hw/rtl/qtu_pkg.sv */
// Shared types and constants for the Q-table update and convergence unit.
// No dependencies.
package qtu_pkg;
  localparam int NumStates  = 256;
  localparam int NumActions = 16;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_LOAD   = 2'd2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // one queued command between front and back
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  state_index;
    logic [3:0]  action_index;
    logic [7:0]  next_state_index;
    logic [3:0]  next_action_index;
    logic [31:0] value_in;
    logic        compare_flag;
  } cmd_t;
endpackage

/* hw/rtl/qtu_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module qtu_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/qtu_front.sv */
// Front part: accepts input items into a two-entry command queue.
// Depends on qtu_pkg.
module qtu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qtu_pkg::cmd_t in_cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output qtu_pkg::cmd_t cmd
);
  qtu_pkg::cmd_t slot [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hw/rtl/qtu_back.sv */
// Back part: runs load, update and check on the value table; others answer zero.
// Depends on qtu_pkg and qtu_ram.
module qtu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [16:0]   learning_rate,
  input  logic [16:0]   discount_factor,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  qtu_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind_echo,
  output logic [31:0]   q_value,
  output logic          converged
);
  localparam int NumStates  = qtu_pkg::NumStates;
  localparam int NumActions = qtu_pkg::NumActions;
  localparam int SW = (NumStates > 1) ? $clog2(NumStates) : 1;
  localparam int AW = $clog2(NumActions);
  localparam int TW = SW + AW;
  localparam int TD = NumStates * NumActions;
  localparam int BW = (AW > 4) ? AW : 4;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD1   = 4'd1;
  localparam logic [3:0] ST_RD2   = 4'd2;
  localparam logic [3:0] ST_MUL1  = 4'd3;
  localparam logic [3:0] ST_TGT   = 4'd4;
  localparam logic [3:0] ST_MUL2  = 4'd5;
  localparam logic [3:0] ST_MUL3  = 4'd6;
  localparam logic [3:0] ST_FIN   = 4'd7;
  localparam logic [3:0] ST_SCAN  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;
  localparam logic [3:0] ST_CLR   = 4'd10;

  logic [3:0]        state;
  qtu_pkg::cmd_t     cur;
  logic [TW-1:0]     here_addr;
  logic [TW-1:0]     next_addr;
  logic [16:0]       alpha;
  logic [16:0]       delta;
  logic [TW-1:0]     clr_idx;

  // table ports
  logic              t_we;
  logic [TW-1:0]     t_waddr;
  logic [31:0]       t_wdata;
  logic [TW-1:0]     t_raddr;
  logic [31:0]       t_rdata;

  // update datapath registers
  logic signed [31:0] q_here;
  logic signed [49:0] prod;
  logic signed [34:0] target;
  logic signed [51:0] part_a;
  logic signed [52:0] part_b;

  // scan counters and running max
  logic [TW:0]        scan_idx;
  logic               scan_rd_v;
  logic [AW-1:0]      scan_col;
  logic [SW-1:0]      scan_row;
  logic signed [31:0] top;
  logic [AW-1:0]      best;
  logic [AW-1:0]      best_fin;
  logic               all_same;

  // argmax store ports
  logic               b_we;
  logic [SW-1:0]      b_waddr;
  logic [BW-1:0]      b_wdata;
  logic [BW-1:0]      b_rdata;

  logic signed [52:0] sum_r;
  logic signed [36:0] rnd_r;

  assign alpha = (learning_rate > qtu_pkg::ONE_Q16) ? qtu_pkg::ONE_Q16 : learning_rate;
  assign delta = (discount_factor > qtu_pkg::ONE_Q16) ? qtu_pkg::ONE_Q16 : discount_factor;

  assign here_addr = {cmd.state_index[SW-1:0], cmd.action_index[AW-1:0]};
  assign next_addr = {cmd.next_state_index[SW-1:0], cmd.next_action_index[AW-1:0]};
  assign cmd_ready = (state == ST_IDLE) && !out_valid;

  // value table
  qtu_ram #(.Width(32), .Depth(TD)) u_table (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  // argmax store, read in step with the scan, one row per stored entry
  qtu_ram #(.Width(BW), .Depth(NumStates)) u_best (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(scan_idx[TW-1:AW]),
    .rdata(b_rdata)
  );

  // read address: next entry first, then current, or the scan index
  always_comb begin
    t_raddr = here_addr;
    unique case (state)
      ST_IDLE: t_raddr = next_addr;
      ST_SCAN: t_raddr = scan_idx[TW-1:0];
      default: t_raddr = {cur.state_index[SW-1:0], cur.action_index[AW-1:0]};
    endcase
  end

  assign sum_r  = part_a + part_b + 53'sd32768;
  assign rnd_r  = 37'(sum_r >>> 16);

  // table writes: clearing pass, load, then update result
  always_comb begin
    t_we    = 1'b0;
    t_waddr = {cur.state_index[SW-1:0], cur.action_index[AW-1:0]};
    t_wdata = 32'd0;
    if (state == ST_CLR) begin
      t_we    = 1'b1;
      t_waddr = clr_idx;
    end else if (state == ST_IDLE && cmd_valid && cmd_ready &&
                 cmd.kind == qtu_pkg::KIND_LOAD) begin
      t_we    = 1'b1;
      t_waddr = here_addr;
      t_wdata = cmd.value_in;
    end else if (state == ST_FIN) begin
      t_we = 1'b1;
      if (rnd_r > 37'sd2147483647) t_wdata = 32'h7FFF_FFFF;
      else if (rnd_r < -37'sd2147483648) t_wdata = 32'h8000_0000;
      else t_wdata = rnd_r[31:0];
    end
  end

  // argmax of the row whose last column is in hand
  assign best_fin = ($signed(t_rdata) > top) ? scan_col : best;

  // argmax store writes: clearing pass, then the end of each row
  always_comb begin
    b_we    = 1'b0;
    b_waddr = scan_row;
    b_wdata = BW'(best_fin);
    if (state == ST_CLR) begin
      b_we    = 1'b1;
      b_waddr = clr_idx[SW-1:0];
      b_wdata = '0;
    end else if (state == ST_SCAN && scan_rd_v && scan_col == AW'(NumActions - 1)) begin
      b_we = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_CLR: begin
          // zero the table and the argmax store once after reset
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == TW'(TD - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            priority if (cmd.kind == qtu_pkg::KIND_UPDATE) begin
              state <= ST_RD1;
            end else if (cmd.kind == qtu_pkg::KIND_CHECK) begin
              scan_idx  <= '0;
              scan_rd_v <= 1'b0;
              all_same  <= 1'b1;
              state     <= ST_SCAN;
            end else begin
              kind_echo <= cmd.kind;
              q_value   <= (cmd.kind == qtu_pkg::KIND_LOAD) ? cmd.value_in : 32'd0;
              converged <= 1'b0;
              out_valid <= 1'b1;
            end
          end
        end
        ST_RD1: begin
          // next entry data arrives
          prod  <= $signed({1'b0, delta}) * $signed(t_rdata);
          state <= ST_RD2;
        end
        ST_RD2: begin
          q_here <= t_rdata;
          state  <= ST_MUL1;
        end
        ST_MUL1: begin
          target <= 35'($signed(cur.value_in)) + 35'((prod + 50'sd32768) >>> 16);
          state  <= ST_TGT;
        end
        ST_TGT: begin
          part_a <= 52'($signed({1'b0, qtu_pkg::ONE_Q16 - alpha}) * q_here);
          state  <= ST_MUL2;
        end
        ST_MUL2: begin
          part_b <= 53'($signed({1'b0, alpha}) * target);
          state  <= ST_FIN;
        end
        ST_FIN: begin
          kind_echo <= cur.kind;
          q_value   <= t_wdata;
          converged <= 1'b0;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_SCAN: begin
          // issue reads one per cycle; compare each read's data in the next cycle
          if (scan_idx < (TW+1)'(TD)) scan_idx <= scan_idx + 1'b1;
          scan_rd_v <= (scan_idx < (TW+1)'(TD));
          scan_col  <= scan_idx[AW-1:0];
          scan_row  <= scan_idx[TW-1:AW];
          if (scan_rd_v) begin
            if (scan_col == '0) begin
              top  <= t_rdata;
              best <= '0;
            end else if ($signed(t_rdata) > top) begin
              top  <= t_rdata;
              best <= scan_col;
            end
            if (scan_col == AW'(NumActions - 1)) begin
              if (b_rdata != b_wdata) all_same <= 1'b0;
            end
          end else if (scan_idx == (TW+1)'(TD)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          kind_echo <= cur.kind;
          q_value   <= 32'd0;
          converged <= cur.compare_flag && all_same;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/q_table_update_and_convergence_unit.sv */
// Q-table update and convergence unit: top level with APB registers.
// Depends on qtu_pkg, qtu_front, qtu_back.
//
// After reset the unit zeroes the value table and the argmax store; the queue
// takes two items meanwhile. A load result is registered and valid in the cycle
// after its command leaves the queue. An update result follows the next-entry
// read, current-entry read, three registered multiplies, then saturate and
// write; a check result follows a scan of the value table at one entry per
// cycle. The back end takes no new command until the result transfers, and
// can take the next one in the cycle after that. A two-entry queue in front
// keeps accepting items while the back end works, until both entries are full.
module q_table_update_and_convergence_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  state_index,
  input  logic [3:0]  action_index,
  input  logic [7:0]  next_state_index,
  input  logic [3:0]  next_action_index,
  input  logic [31:0] value_in,
  input  logic        compare_flag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind_echo,
  output logic [31:0] q_value,
  output logic        converged
);
  localparam logic [2:0] ADDR_LR = 3'd0;
  localparam logic [2:0] ADDR_DF = 3'd4;

  logic [16:0]   learning_rate;
  logic [16:0]   discount_factor;
  qtu_pkg::cmd_t in_cmd;
  qtu_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate   <= '0;
      discount_factor <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_LR) learning_rate   <= pwdata[16:0];
      if (paddr == ADDR_DF) discount_factor <= pwdata[16:0];
    end
  end

  // register reads
  always_comb begin
    prdata = 32'd0;
    if (paddr == ADDR_LR) prdata = {15'd0, learning_rate};
    else if (paddr == ADDR_DF) prdata = {15'd0, discount_factor};
  end

  assign in_cmd = '{kind: kind, state_index: state_index, action_index: action_index,
                    next_state_index: next_state_index,
                    next_action_index: next_action_index,
                    value_in: value_in, compare_flag: compare_flag};

  qtu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  qtu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .learning_rate  (learning_rate),
    .discount_factor(discount_factor),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind_echo      (kind_echo),
    .q_value        (q_value),
    .converged      (converged)
  );
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the Q-table update and convergence unit.
// Depends on qtu_pkg and q_table_update_and_convergence_unit. An internal value
// predictor checks every result, and the stimulus covers loads, updates and scans.
module tb_top;
  localparam logic [2:0] ADDR_LEARNING_RATE   = 3'd0;
  localparam logic [2:0] ADDR_DISCOUNT_FACTOR = 3'd4;
  localparam logic [1:0] KIND_NONE            = 2'd3;
  localparam int         NumStates            = qtu_pkg::NumStates;
  localparam int         NumActions           = qtu_pkg::NumActions;
  localparam int         CELLS                = NumStates * NumActions;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] q_value;
    logic        converged;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  state_index;
  logic [3:0]  action_index;
  logic [7:0]  next_state_index;
  logic [3:0]  next_action_index;
  logic [31:0] value_in;
  logic        compare_flag;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind_echo;
  logic [31:0] q_value;
  logic        converged;

  // predictor copy of the table, argmax store and registers
  int          q_table[CELLS];
  logic [3:0]  best_action[NumStates];
  logic [16:0] alpha_reg;
  logic [16:0] delta_reg;

  answer_t     pending_answers[$];
  int          mismatches = 0;
  int          hold_requests;
  bit          calm;
  int          check_budget;

  q_table_update_and_convergence_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint round_q16(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // advance the predictor by one item and return the answer it should give
  function automatic answer_t predict_answer(qtu_pkg::cmd_t c);
    answer_t     ans;
    longint      a;
    longint      d;
    longint      tgt;
    longint      r;
    int          here;
    int          there;
    int          top;
    logic [3:0]  arg;
    bit          same;
    ans   = '0;
    ans.kind = c.kind;
    here  = int'({c.state_index, c.action_index});
    there = int'({c.next_state_index, c.next_action_index});
    case (c.kind)
      qtu_pkg::KIND_UPDATE: begin
        a   = (alpha_reg > qtu_pkg::ONE_Q16) ? 65536 : longint'(alpha_reg);
        d   = (delta_reg > qtu_pkg::ONE_Q16) ? 65536 : longint'(delta_reg);
        tgt = longint'($signed(c.value_in)) + round_q16(d * longint'(q_table[there]));
        r   = round_q16((65536 - a) * longint'(q_table[here]) + a * tgt);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        q_table[here] = int'(r);
        ans.q_value = r[31:0];
      end
      qtu_pkg::KIND_CHECK: begin
        same = 1'b1;
        for (int s = 0; s < NumStates; s++) begin
          arg = '0;
          top = q_table[s * NumActions];
          for (int j = 1; j < NumActions; j++) begin
            if (q_table[s * NumActions + j] > top) begin
              top = q_table[s * NumActions + j];
              arg = j[3:0];
            end
          end
          if (arg != best_action[s]) same = 1'b0;
          best_action[s] = arg;
        end
        ans.converged = c.compare_flag && same;
      end
      qtu_pkg::KIND_LOAD: begin
        q_table[here] = c.value_in;
        ans.q_value = c.value_in;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // drive one item, hold it until the transfer, then record the expected answer
  task automatic send_item(qtu_pkg::cmd_t c);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    kind              <= c.kind;
    state_index       <= c.state_index;
    action_index      <= c.action_index;
    next_state_index  <= c.next_state_index;
    next_action_index <= c.next_action_index;
    value_in          <= c.value_in;
    compare_flag      <= c.compare_flag;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(predict_answer(c));
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending until every expected answer has come back
  task automatic drain();
    go_idle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LEARNING_RATE) alpha_reg = data[16:0];
    else delta_reg = data[16:0];
    @(posedge clk);
  endtask

  function automatic qtu_pkg::cmd_t make_cmd(logic [1:0] k, int s, int a, int ns, int na,
                                             logic [31:0] v, bit cmp);
    qtu_pkg::cmd_t c;
    c.kind              = k;
    c.state_index       = s[7:0];
    c.action_index      = a[3:0];
    c.next_state_index  = ns[7:0];
    c.next_action_index = na[3:0];
    c.value_in          = v;
    c.compare_flag      = cmp;
    return c;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      4: return 32'(signed'($urandom_range(0, 6)) - 3) <<< 16;
      default: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'd131071;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  // compare each transfer on the result side with the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result kind_echo=%0d q_value=%h", kind_echo, q_value);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (kind_echo !== want.kind) begin
          $error("kind_echo expected %0d actual %0d", want.kind, kind_echo);
          mismatches++;
        end
        if (q_value !== want.q_value) begin
          $error("q_value expected %h actual %h", want.q_value, q_value);
          mismatches++;
        end
        if (converged !== want.converged) begin
          $error("converged expected %0b actual %0b", want.converged, converged);
          mismatches++;
        end
      end
    end
  end

  // result-side ready: random short stalls, plus long holds on request
  initial begin
    int stall;
    int hold_left;
    int holds_seen;
    stall = 0;
    hold_left = 0;
    holds_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // extremes of loads, every kind but check, saturation both ways, rate above one
  task automatic test_directed();
    write_reg(ADDR_LEARNING_RATE, 32'd65536);
    write_reg(ADDR_DISCOUNT_FACTOR, 32'd65536);
    send_item(make_cmd(qtu_pkg::KIND_LOAD, 0, 0, 255, 15, 32'h7fffffff, 1'b1));
    send_item(make_cmd(qtu_pkg::KIND_LOAD, 255, 15, 0, 0, 32'h80000000, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_LOAD, 128, 8, 0, 0, 32'h00000000, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 0, 0, 0, 0, 32'h7fffffff, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 255, 15, 255, 15, 32'h80000000, 1'b1));
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 128, 8, 0, 0, 32'hffff8000, 1'b0));
    send_item(make_cmd(KIND_NONE, 255, 15, 255, 15, 32'hffffffff, 1'b1));
    drain();
    write_reg(ADDR_LEARNING_RATE, 32'd131071);
    write_reg(ADDR_DISCOUNT_FACTOR, 32'd131071);
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 128, 8, 255, 15, 32'h00018000, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 0, 0, 128, 8, 32'h00008000, 1'b0));
    drain();
    write_reg(ADDR_LEARNING_RATE, 32'd0);
    write_reg(ADDR_DISCOUNT_FACTOR, 32'd0);
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 128, 8, 0, 0, 32'h12345678, 1'b0));
    drain();
    write_reg(ADDR_LEARNING_RATE, 32'd32768);
    write_reg(ADDR_DISCOUNT_FACTOR, 32'd1);
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 0, 0, 255, 15, 32'hffffffff, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_UPDATE, 255, 15, 128, 8, 32'h00000001, 1'b0));
  endtask

  // load the first sixteen rows with mostly small values so that ties are common
  task automatic test_fill_table();
    logic [31:0] v;
    for (int i = 0; i < 16 * NumActions; i++) begin
      v = ($urandom_range(0, 3) == 0) ? pick_value() : ($urandom_range(0, 3) << 16);
      send_item(make_cmd(qtu_pkg::KIND_LOAD, i / NumActions, i % NumActions,
                         $urandom_range(0, 255), $urandom_range(0, 15), v,
                         $urandom_range(0, 1) != 0));
    end
  endtask

  // store only, compare on an unchanged table, then move one argmax
  task automatic test_convergence();
    send_item(make_cmd(qtu_pkg::KIND_CHECK, 0, 0, 0, 0, 32'h0, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_CHECK, 255, 15, 255, 15, 32'hffffffff, 1'b1));
    send_item(make_cmd(qtu_pkg::KIND_LOAD, 7, 15, 0, 0, 32'h7fffffff, 1'b0));
    send_item(make_cmd(qtu_pkg::KIND_CHECK, 0, 0, 0, 0, 32'h0, 1'b1));
    send_item(make_cmd(qtu_pkg::KIND_CHECK, 0, 0, 0, 0, 32'h0, 1'b1));
  endtask

  // hold the result side off so the input queue fills and stalls
  task automatic test_backpressure();
    drain();
    hold_requests++;
    for (int i = 0; i < 20; i++)
      send_item(make_cmd(qtu_pkg::KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 255), $urandom_range(0, 15), pick_value(), 1'b0));
    drain();
  endtask

  task automatic random_phase(int count);
    int    roll;
    logic [1:0] k;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) k = qtu_pkg::KIND_UPDATE;
      else if (roll < 93) k = qtu_pkg::KIND_LOAD;
      else if (roll < 96 && check_budget > 0) k = qtu_pkg::KIND_CHECK;
      else k = ($urandom_range(0, 1) != 0) ? KIND_NONE : qtu_pkg::KIND_UPDATE;
      if (k == qtu_pkg::KIND_CHECK) check_budget--;
      send_item(make_cmd(k, $urandom_range(0, 255), $urandom_range(0, 15),
                         $urandom_range(0, 255), $urandom_range(0, 15),
                         pick_value(), $urandom_range(0, 1) != 0));
    end
  endtask

  // random traffic under several register settings, the last without idling
  task automatic test_random();
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(ADDR_LEARNING_RATE, pick_rate());
      write_reg(ADDR_DISCOUNT_FACTOR, pick_rate());
      if (p == 4) calm = 1'b1;
      random_phase(250);
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    kind <= '0;
    state_index <= '0;
    action_index <= '0;
    next_state_index <= '0;
    next_action_index <= '0;
    value_in <= '0;
    compare_flag <= 1'b0;
    hold_requests = 0;
    calm = 1'b0;
    check_budget = 20;
    alpha_reg = '0;
    delta_reg = '0;
    for (int i = 0; i < NumStates; i++) best_action[i] = '0;
    for (int i = 0; i < CELLS; i++) q_table[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_table();
    test_convergence();
    test_backpressure();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/qtu_pkg.sv
hw/rtl/qtu_ram.sv
hw/rtl/qtu_front.sv
hw/rtl/qtu_back.sv
hw/rtl/q_table_update_and_convergence_unit.sv
tb/tb_top.sv
